[rtl/core/fpsm_pkg.sv]
`default_nettype none
// ============================================================================
// fpsm_pkg
// Shared types and constants of the five-point stencil matrix-vector block:
// item layouts, kind and register codes, and the control groups that pass
// between the sequencer, the line store and the arithmetic pipeline.
// ============================================================================

package fpsm_pkg;

    // fixed-point format
    localparam int VALUE_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * VALUE_W;
    localparam int NUM_TERMS = 5;

    // result field widths
    localparam int ROW_IDX_W = 10;
    localparam int COL_IDX_W = 6;

    // configuration port
    localparam int NUM_COLS_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam logic [NUM_COLS_W-1:0] NUM_COLS_RST = 7'd64;

    // default sizes
    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 1024;

    // stencil term slots
    localparam int TERM_NORTH = 0;
    localparam int TERM_SOUTH = 1;
    localparam int TERM_WEST = 2;
    localparam int TERM_EAST = 3;
    localparam int TERM_CENTER = 4;

    typedef enum logic [1:0] {
        KIND_UPPER = 2'd0,
        KIND_GRID  = 2'd1,
        KIND_LOWER = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_COLS   = 2'd0,
        REG_UPPER_HALO = 2'd1,
        REG_LOWER_HALO = 2'd2
    } cfg_reg_t;

    // input item
    typedef struct packed {
        logic [1:0]                kind;
        logic signed [VALUE_W-1:0] x_value;
        logic signed [VALUE_W-1:0] coef_north;
        logic signed [VALUE_W-1:0] coef_south;
        logic signed [VALUE_W-1:0] coef_west;
        logic signed [VALUE_W-1:0] coef_east;
        logic signed [VALUE_W-1:0] coef_center;
    } point_t;

    // result item
    typedef struct packed {
        logic signed [VALUE_W-1:0] product_value;
        logic [ROW_IDX_W-1:0]      row_index;
        logic [COL_IDX_W-1:0]      col_index;
        logic                      saturated;
        logic                      grid_done;
    } result_t;

    // configuration write
    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [NUM_COLS_W-1:0] value;
    } cfg_write_t;

    // per-item decisions made by the sequencer at accept time
    typedef struct packed {
        logic                 live;
        logic                 emit;
        logic                 grid;
        logic                 ra_halo;
        logic                 halo_keep;
        logic                 south_en;
        logic                 west_en;
        logic                 east_en;
        logic                 grid_done;
        logic [ROW_IDX_W-1:0] row_index;
    } issue_t;

    // identification that travels with a result
    typedef struct packed {
        logic [ROW_IDX_W-1:0] row_index;
        logic [COL_IDX_W-1:0] col_index;
        logic                 grid_done;
    } tag_t;

    // operand set of one stencil evaluation
    typedef struct packed {
        tag_t                                tag;
        logic [NUM_TERMS-1:0][VALUE_W-1:0]   coef;
        logic [NUM_TERMS-1:0][VALUE_W-1:0]   val;
    } op_t;

endpackage

`default_nettype wire

[rtl/core/fpsm_stream_if.sv]
`default_nettype none
// ============================================================================
// fpsm_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ============================================================================

interface fpsm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/fpsm_seq.sv]
`default_nettype none
// ============================================================================
// fpsm_seq
// Sequencer: configuration registers, column and row position, slab state,
// and the per-item decisions handed to the line store.
// ============================================================================

module fpsm_seq #(
    parameter int MAX_COLS = fpsm_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = fpsm_pkg::MAX_ROWS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [1:0]                  kind,
    input  logic                        cfg_we,
    input  fpsm_pkg::cfg_write_t        cfg_wr,
    output logic [$clog2(MAX_COLS)-1:0] col,
    output logic [$clog2(MAX_COLS)-1:0] col_p1,
    output fpsm_pkg::issue_t            issue
);
    import fpsm_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int NW = (COL_W + 1 > NUM_COLS_W) ? COL_W + 1 : NUM_COLS_W;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [NUM_COLS_W-1:0] num_cols_reg;
    logic                  upper_halo_reg;
    logic                  lower_halo_reg;
    logic [COL_W-1:0]      column_counter_reg;
    logic [COL_W-1:0]      column_counter_next;
    logic [ROW_W-1:0]      row_counter_reg;
    logic [ROW_W-1:0]      row_counter_next;
    logic                  frp_reg;
    logic                  frp_next;

    logic [NW-1:0] nc_ext;
    logic [NW-1:0] cols_used;
    logic [NW-1:0] col_p1_ext;
    logic          last;
    logic          is_upper;
    logic          is_grid;
    logic          is_lower;

    // columns in use and the current column
    always_comb
    begin
        nc_ext = NW'(num_cols_reg);
        if (nc_ext == '0)
        begin
            cols_used = NW'(1);
        end
        else if (nc_ext > NW'(MAX_COLS))
        begin
            cols_used = NW'(MAX_COLS);
        end
        else
        begin
            cols_used = nc_ext;
        end
        col = (NW'(column_counter_reg) < cols_used) ? column_counter_reg : '0;
        col_p1_ext = NW'(col) + NW'(1);
        col_p1 = col_p1_ext[COL_W-1:0];
        last = (col_p1_ext >= cols_used);
    end

    // item decisions
    always_comb
    begin
        is_upper = (kind == KIND_UPPER);
        is_grid = (kind == KIND_GRID);
        is_lower = (kind == KIND_LOWER);
        issue.live = is_upper || is_grid || is_lower;
        issue.emit = (is_grid || is_lower) && !frp_reg;
        issue.grid = is_grid;
        issue.ra_halo = is_upper;
        issue.halo_keep = upper_halo_reg;
        issue.south_en = is_grid || lower_halo_reg;
        issue.west_en = (col != '0);
        issue.east_en = !last;
        issue.grid_done = is_lower && last;
        issue.row_index = ROW_IDX_W'(row_counter_reg);
    end

    // position and slab state after this item
    always_comb
    begin
        column_counter_next = last ? '0 : col_p1;
        row_counter_next = row_counter_reg;
        frp_next = frp_reg;
        if (is_upper || (is_lower && last))
        begin
            frp_next = 1'b1;
            row_counter_next = '0;
        end
        else if (is_grid && last)
        begin
            if (frp_reg)
            begin
                frp_next = 1'b0;
            end
            else if (row_counter_reg < ROW_W'(MAX_ROWS - 1))
            begin
                row_counter_next = row_counter_reg + ROW_W'(1);
            end
        end
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= NUM_COLS_RST;
            upper_halo_reg <= 1'b0;
            lower_halo_reg <= 1'b0;
            column_counter_reg <= '0;
            row_counter_reg <= '0;
            frp_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_wr.index)
                    REG_NUM_COLS:   num_cols_reg <= cfg_wr.value;
                    REG_UPPER_HALO: upper_halo_reg <= cfg_wr.value[0];
                    REG_LOWER_HALO: lower_halo_reg <= cfg_wr.value[0];
                    default:        ;
                endcase
            end
            if (accept && issue.live)
            begin
                column_counter_reg <= column_counter_next;
                row_counter_reg <= row_counter_next;
                frp_reg <= frp_next;
            end
        end
    end

    // an upper halo item restarts the slab
    a_upper_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && issue.live && issue.ra_halo |=> frp_reg && (row_counter_reg == '0))
        else $error("upper halo item did not restart the slab");

    // row counter stays within the row range
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_counter_reg <= ROW_W'(MAX_ROWS - 1))
        else $error("row counter beyond last row");

endmodule

`default_nettype wire

[rtl/core/fpsm_store.sv]
`default_nettype none
// ============================================================================
// fpsm_store
// Line store: the point memory (current row values and coefficients), the
// row-above memory with its write-back and forwarding, the west register,
// and the operand stage feeding the arithmetic pipeline.
// ============================================================================

module fpsm_store #(
    parameter int MAX_COLS = fpsm_pkg::MAX_COLS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  fpsm_pkg::point_t            point,
    input  logic [$clog2(MAX_COLS)-1:0] col,
    input  logic [$clog2(MAX_COLS)-1:0] col_p1,
    input  fpsm_pkg::issue_t            issue,
    input  logic                        op_ready,
    output logic                        in_ready,
    output logic                        op_valid,
    output fpsm_pkg::op_t               op
);
    import fpsm_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS);

    typedef struct packed {
        logic [VALUE_W-1:0] x;
        logic [VALUE_W-1:0] n;
        logic [VALUE_W-1:0] s;
        logic [VALUE_W-1:0] w;
        logic [VALUE_W-1:0] e;
        logic [VALUE_W-1:0] c;
    } pt_entry_t;

    pt_entry_t          pt_mem [MAX_COLS];
    logic [VALUE_W-1:0] ra_mem [MAX_COLS];

    pt_entry_t          pt_rd_reg;
    logic [VALUE_W-1:0] east_x_reg;
    logic [VALUE_W-1:0] ra_rd_reg;
    pt_entry_t          pt_wr;

    logic               s1_valid_reg;
    issue_t             s1_issue_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [VALUE_W-1:0] s1_x_reg;
    logic [VALUE_W-1:0] s1_halo_reg;
    logic               byp_hit_reg;
    logic [VALUE_W-1:0] byp_data_reg;
    logic [VALUE_W-1:0] west_reg;

    logic               clr_active_reg;
    logic [COL_W-1:0]   clr_addr_reg;

    logic               s1_free;
    logic               s1_adv;
    logic               s1_ra_we;
    logic [VALUE_W-1:0] s1_ra_wdata;
    logic               ra_we;
    logic [COL_W-1:0]   ra_waddr;
    logic [VALUE_W-1:0] ra_wdata;
    logic [VALUE_W-1:0] ra_val;

    // stage one moves on when downstream takes it or it carries no result
    assign s1_adv = s1_valid_reg && (!s1_issue_reg.emit || op_ready);
    assign s1_free = !s1_valid_reg || !s1_issue_reg.emit || op_ready;
    assign in_ready = s1_free && !clr_active_reg;

    // row-above write-back: clearing zeros, halo value or the replaced current-row value
    always_comb
    begin
        s1_ra_we = s1_adv && (s1_issue_reg.ra_halo ||
                              (s1_issue_reg.grid && s1_issue_reg.emit));
        s1_ra_wdata = s1_issue_reg.ra_halo ? s1_halo_reg : pt_rd_reg.x;
        if (clr_active_reg)
        begin
            ra_we = 1'b1;
            ra_waddr = clr_addr_reg;
            ra_wdata = '0;
        end
        else
        begin
            ra_we = s1_ra_we;
            ra_waddr = s1_col_reg;
            ra_wdata = s1_ra_wdata;
        end
    end

    // new point entry
    always_comb
    begin
        pt_wr.x = point.x_value;
        pt_wr.n = point.coef_north;
        pt_wr.s = point.coef_south;
        pt_wr.w = point.coef_west;
        pt_wr.e = point.coef_east;
        pt_wr.c = point.coef_center;
    end

    // memories: read at accept, old data on a same-entry write
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pt_rd_reg <= pt_mem[col];
            east_x_reg <= pt_mem[col_p1].x;
            ra_rd_reg <= ra_mem[col];
            if (issue.live && issue.grid)
            begin
                pt_mem[col] <= pt_wr;
            end
        end
        if (ra_we)
        begin
            ra_mem[ra_waddr] <= ra_wdata;
        end
    end

    // stage one payload and forwarding of a same-edge row-above write
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_issue_reg <= issue;
            s1_col_reg <= col;
            s1_x_reg <= point.x_value;
            s1_halo_reg <= issue.halo_keep ? point.x_value : '0;
            byp_data_reg <= s1_ra_wdata;
        end
    end

    // stage one control, west value, clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg <= 1'b0;
            west_reg <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= accept && issue.live;
            end
            if (accept)
            begin
                byp_hit_reg <= s1_ra_we && (s1_col_reg == col);
            end
            if (s1_adv && s1_issue_reg.emit)
            begin
                west_reg <= pt_rd_reg.x;
            end
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + COL_W'(1);
                if (clr_addr_reg == COL_W'(MAX_COLS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
        end
    end

    // operand set
    assign ra_val = byp_hit_reg ? byp_data_reg : ra_rd_reg;
    assign op_valid = s1_valid_reg && s1_issue_reg.emit;

    always_comb
    begin
        op.tag.row_index = s1_issue_reg.row_index;
        op.tag.col_index = COL_IDX_W'(s1_col_reg);
        op.tag.grid_done = s1_issue_reg.grid_done;
        op.coef[TERM_NORTH] = pt_rd_reg.n;
        op.coef[TERM_SOUTH] = pt_rd_reg.s;
        op.coef[TERM_WEST] = pt_rd_reg.w;
        op.coef[TERM_EAST] = pt_rd_reg.e;
        op.coef[TERM_CENTER] = pt_rd_reg.c;
        op.val[TERM_NORTH] = ra_val;
        op.val[TERM_SOUTH] = s1_issue_reg.south_en ? s1_x_reg : '0;
        op.val[TERM_WEST] = s1_issue_reg.west_en ? west_reg : '0;
        op.val[TERM_EAST] = s1_issue_reg.east_en ? east_x_reg : '0;
        op.val[TERM_CENTER] = pt_rd_reg.x;
    end

    // a stalled operand set keeps its memory data
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && !op_ready |=> op_valid && $stable(pt_rd_reg) && $stable(ra_val))
        else $error("operands changed while stalled");

    // nothing is in flight while the row-above memory is being cleared
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s1_valid_reg && !accept)
        else $error("item in flight during clearing pass");

endmodule

`default_nettype wire

[rtl/core/fpsm_datapath.sv]
`default_nettype none
// ============================================================================
// fpsm_datapath
// Arithmetic pipeline: five signed products, exact sum, floor to Q16.16,
// saturation, and the output register.
// ============================================================================

module fpsm_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    input  fpsm_pkg::op_t     op,
    output logic              op_ready,
    output logic              out_valid,
    output fpsm_pkg::result_t out_data,
    input  logic              out_ready
);
    import fpsm_pkg::*;

    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W = PROD_W + 3;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W - VALUE_W + 1){1'b1}}, {(VALUE_W - 1){1'b0}}};

    logic                      p_valid_reg;
    tag_t                      p_tag_reg;
    logic signed [PROD_W-1:0]  prod_reg [NUM_TERMS];
    logic signed [PROD_W-1:0]  prod_next [NUM_TERMS];
    logic signed [VALUE_W-1:0] mul_a [NUM_TERMS];
    logic signed [VALUE_W-1:0] mul_b [NUM_TERMS];

    logic                      s_valid_reg;
    tag_t                      s_tag_reg;
    logic signed [PAIR_W-1:0]  sum_a_reg;
    logic signed [PAIR_W-1:0]  sum_b_reg;
    logic signed [PROD_W-1:0]  sum_c_reg;

    logic                      t_valid_reg;
    tag_t                      t_tag_reg;
    logic signed [SUM_W-1:0]   total_reg;

    logic                      o_valid_reg;
    result_t                   o_data_reg;
    result_t                   o_data_next;
    logic signed [SUM_W-1:0]   shifted;

    logic p_free;
    logic s_free;
    logic t_free;
    logic o_free;

    // stall chain, a bubble is filled from upstream
    assign o_free = !o_valid_reg || out_ready;
    assign t_free = !t_valid_reg || o_free;
    assign s_free = !s_valid_reg || t_free;
    assign p_free = !p_valid_reg || s_free;
    assign op_ready = p_free;
    assign out_valid = o_valid_reg;
    assign out_data = o_data_reg;

    // one multiplier per term
    always_comb
    begin
        for (int i = 0; i < NUM_TERMS; i++)
        begin
            mul_a[i] = op.coef[i];
            mul_b[i] = op.val[i];
            prod_next[i] = mul_a[i] * mul_b[i];
        end
    end

    // floor to Q16.16 and clip
    always_comb
    begin
        shifted = total_reg >>> FRAC_W;
        o_data_next.row_index = t_tag_reg.row_index;
        o_data_next.col_index = t_tag_reg.col_index;
        o_data_next.grid_done = t_tag_reg.grid_done;
        if (shifted > SAT_HI)
        begin
            o_data_next.product_value = SAT_HI[VALUE_W-1:0];
            o_data_next.saturated = 1'b1;
        end
        else if (shifted < SAT_LO)
        begin
            o_data_next.product_value = SAT_LO[VALUE_W-1:0];
            o_data_next.saturated = 1'b1;
        end
        else
        begin
            o_data_next.product_value = shifted[VALUE_W-1:0];
            o_data_next.saturated = 1'b0;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (p_free)
        begin
            p_tag_reg <= op.tag;
            for (int i = 0; i < NUM_TERMS; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
        end
        if (s_free)
        begin
            s_tag_reg <= p_tag_reg;
            sum_a_reg <= PAIR_W'(prod_reg[TERM_NORTH]) + PAIR_W'(prod_reg[TERM_SOUTH]);
            sum_b_reg <= PAIR_W'(prod_reg[TERM_WEST]) + PAIR_W'(prod_reg[TERM_EAST]);
            sum_c_reg <= prod_reg[TERM_CENTER];
        end
        if (t_free)
        begin
            t_tag_reg <= s_tag_reg;
            total_reg <= SUM_W'(sum_a_reg) + SUM_W'(sum_b_reg) + SUM_W'(sum_c_reg);
        end
        if (o_free)
        begin
            o_data_reg <= o_data_next;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            t_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_free)
            begin
                p_valid_reg <= op_valid;
            end
            if (s_free)
            begin
                s_valid_reg <= p_valid_reg;
            end
            if (t_free)
            begin
                t_valid_reg <= s_valid_reg;
            end
            if (o_free)
            begin
                o_valid_reg <= t_valid_reg;
            end
        end
    end

    // a clipped result sits at one of the range limits
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_data_reg.saturated |->
            (o_data_reg.product_value == SAT_HI[VALUE_W-1:0]) ||
            (o_data_reg.product_value == SAT_LO[VALUE_W-1:0]))
        else $error("saturated result not at a range limit");

endmodule

`default_nettype wire

[rtl/core/five_point_stencil_matvec.sv]
`default_nettype none
// ============================================================================
// five_point_stencil_matvec
// Variable-coefficient five-point stencil product over a grid slab streamed
// in raster order, one halo row above and one below, Q16.16 arithmetic.
// ============================================================================
//
//   channel   dir   payload       handshake
//   points    in    point_t       valid / ready
//   results   out   result_t      valid / ready
//   cfg       in    cfg_write_t   valid / ready (ready always high)
//
// one item per cycle sustained while results are taken; each result is
// registered at memory read, products, pair sums, total, output register
// after reset the row-above memory is cleared, one entry a cycle, while
// points.ready is low; cfg writes are taken throughout
// a stalled result holds the pipeline stage by stage; points are still
// taken while any stage ahead has room

module five_point_stencil_matvec #(
    parameter int MAX_COLS = fpsm_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = fpsm_pkg::MAX_ROWS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    fpsm_stream_if.sink   points,
    fpsm_stream_if.source results,
    fpsm_stream_if.sink   cfg
);
    import fpsm_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS);

    logic             accept;
    logic             in_ready;
    logic             cfg_we;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] col_p1;
    issue_t           issue;
    logic             op_valid;
    logic             op_ready;
    op_t              op;
    logic             out_valid;
    result_t          out_data;

    // handshakes
    assign points.ready = in_ready;
    assign accept = points.valid && in_ready;
    assign cfg.ready = 1'b1;
    assign cfg_we = cfg.valid;
    assign results.valid = out_valid;
    assign results.data = out_data;

    // position, slab state, configuration
    fpsm_seq #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .kind   (points.data.kind),
        .cfg_we (cfg_we),
        .cfg_wr (cfg.data),
        .col    (col),
        .col_p1 (col_p1),
        .issue  (issue)
    );

    // line memories and operand stage
    fpsm_store #(
        .MAX_COLS (MAX_COLS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .point    (points.data),
        .col      (col),
        .col_p1   (col_p1),
        .issue    (issue),
        .op_ready (op_ready),
        .in_ready (in_ready),
        .op_valid (op_valid),
        .op       (op)
    );

    // arithmetic pipeline and output register
    fpsm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op        (op),
        .op_ready  (op_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_ready (results.ready)
    );

endmodule

`default_nettype wire
